// ===== hdl/aprd_pkg.sv =====
// Package: widths, record codes, register indexes and scaling constants of the pointer decoder.
`timescale 1ns / 1ps
package aprd_pkg;

  localparam int unsigned SIZE_W   = 14;
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned AXIS_W   = 15;
  localparam int unsigned PIXEL_W  = 13;
  localparam int unsigned PRESS_W  = 3;
  localparam int unsigned TYPE_W   = 8;
  localparam int unsigned BUTTON_W = 16;

  // Buttons kept in a pointer event, clamped to the button word.
  localparam int unsigned BUTTON_COUNT = 3;
  localparam int unsigned BUTTON_KEEP  = (BUTTON_COUNT > BUTTON_W) ? BUTTON_W : BUTTON_COUNT;
  localparam logic [BUTTON_W-1:0] BUTTON_MASK =
    BUTTON_W'((32'd1 << BUTTON_KEEP) - 32'd1);

  localparam logic [RAW_W-1:0]   AXIS_MAX   = 16'd32767;
  localparam logic [AXIS_W-1:0]  AXIS_ROUND = 15'd16383;
  localparam logic [PIXEL_W-1:0] PIXEL_MAX  = 13'd8191;

  localparam logic [TYPE_W-1:0] REC_POINTER = 8'h01;
  localparam logic [TYPE_W-1:0] REC_RELEASE = 8'h03;

  localparam logic REQ_RING  = 1'b0;
  localparam logic REQ_REARM = 1'b1;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RESET  = 14'd1024;
  localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RESET = 14'd768;

endpackage

// ===== hdl/aprd_rec_if.sv =====
// Interface: input record channel (valid/ready plus record fields).
`timescale 1ns / 1ps
interface aprd_rec_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [aprd_pkg::TYPE_W-1:0]      event_type;
  logic [aprd_pkg::RAW_W-1:0]       raw_x;
  logic [aprd_pkg::RAW_W-1:0]       raw_y;
  logic [aprd_pkg::BUTTON_W-1:0]    button_word;

  modport source (output valid, req_type, event_type, raw_x, raw_y, button_word,
                  input ready);
  modport sink   (input valid, req_type, event_type, raw_x, raw_y, button_word,
                  output ready);
endinterface

// ===== hdl/aprd_evt_if.sv =====
// Interface: output pointer event channel (valid/ready plus event fields).
`timescale 1ns / 1ps
interface aprd_evt_if;
  logic                          valid;
  logic                          ready;
  logic [aprd_pkg::PIXEL_W-1:0]  pixel_x;
  logic [aprd_pkg::PIXEL_W-1:0]  pixel_y;
  logic [aprd_pkg::PRESS_W-1:0]  pressed;

  modport source (output valid, pixel_x, pixel_y, pressed, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pressed, output ready);
endinterface

// ===== hdl/aprd_axis_scale.sv =====
// Axis scaler: maps a 15-bit normalized axis to 0..size-1 pixels with rounding, clamped to 8191.
`timescale 1ns / 1ps
module aprd_axis_scale (
  input  logic [aprd_pkg::AXIS_W-1:0]  axis,
  input  logic [aprd_pkg::SIZE_W-1:0]  size,
  output logic [aprd_pkg::PIXEL_W-1:0] pixel
);
  import aprd_pkg::*;

  localparam int unsigned PROD_W = AXIS_W + SIZE_W;
  localparam int unsigned NUM_W  = PROD_W + 1;

  logic [SIZE_W-1:0]   size_m1;
  logic [PROD_W-1:0]   prod;
  logic [NUM_W-1:0]    num;
  logic [AXIS_W-1:0]   hi;
  logic [AXIS_W-1:0]   lo;
  logic [AXIS_W:0]     fold;
  logic [1:0]          corr;
  logic [AXIS_W-1:0]   quot;

  // num / (2^15 - 1): num = hi*2^15 + lo = hi*(2^15-1) + (hi+lo),
  // and hi+lo stays below 2*(2^15-1)+1, so the correction is 0, 1 or 2.
  always_comb begin
    size_m1 = size - SIZE_W'(1);
    prod    = PROD_W'(axis) * PROD_W'(size_m1);
    num     = NUM_W'(prod) + NUM_W'(AXIS_ROUND);
    hi      = num[NUM_W-1 -: AXIS_W];
    lo      = num[AXIS_W-1:0];
    fold    = {1'b0, hi} + {1'b0, lo};
    if (fold >= {AXIS_MAX[AXIS_W-1:0], 1'b0}) begin
      corr = 2'd2;
    end else if (fold >= {1'b0, AXIS_MAX[AXIS_W-1:0]}) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    quot = hi + AXIS_W'(corr);
    if (size <= SIZE_W'(1)) begin
      pixel = '0;
    end else if (quot > AXIS_W'(PIXEL_MAX)) begin
      pixel = PIXEL_MAX;
    end else begin
      pixel = quot[PIXEL_W-1:0];
    end
  end

endmodule

// ===== hdl/abs_pointer_record_decoder_unit.sv =====
// Top level: absolute pointer record decoder with APB configuration port.
`timescale 1ns / 1ps
// Takes one record per cycle unless the sink stalls and turns pointer
// records into pixel events. A record is captured in an input register,
// then scaled and checked in one pass (one 15x14 multiply and a
// divide-by-32767 fold per axis) into the output register, where it
// waits for the sink. Sustained rate is one record per cycle while the
// sink takes events; the input keeps accepting while an event
// waits, as long as the record in the input register either produces nothing
// or can move into the output register. Pointer records with an axis above
// 32767 are dropped; release-all emits the last position with buttons up only
// when buttons are held; rearm clears held buttons silently; other types are
// ignored. Registers: screen_width at byte 0x0, screen_height at byte 0x4
// (14 bits each, reset 1024 and 768); write them only while idle.
module abs_pointer_record_decoder_unit (
  input  logic                           clk,
  input  logic                           rst,
  aprd_rec_if.sink                       in_ch,
  aprd_evt_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [aprd_pkg::PADDR_W-1:0]   paddr,
  input  logic [aprd_pkg::PDATA_W-1:0]   pwdata,
  output logic [aprd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import aprd_pkg::*;

  // configuration registers
  logic [SIZE_W-1:0] screen_width;
  logic [SIZE_W-1:0] screen_height;
  logic              cfg_wr;
  logic              cfg_idx;

  // input register stage
  logic                s1_valid;
  logic                s1_req;
  logic [TYPE_W-1:0]   s1_type;
  logic [RAW_W-1:0]    s1_x;
  logic [RAW_W-1:0]    s1_y;
  logic [BUTTON_W-1:0] s1_bt;

  // decoder state
  logic [BUTTON_W-1:0] held_buttons;
  logic [BUTTON_W-1:0] held_buttons_next;
  logic [PIXEL_W-1:0]  last_pixel_x;
  logic [PIXEL_W-1:0]  last_pixel_y;

  // output register
  logic                out_valid;
  logic [PIXEL_W-1:0]  out_x;
  logic [PIXEL_W-1:0]  out_y;
  logic [PRESS_W-1:0]  out_press;

  logic               scaled_ok;
  logic [PIXEL_W-1:0] scaled_x;
  logic [PIXEL_W-1:0] scaled_y;
  logic               is_pointer;
  logic               is_release;
  logic               emit;
  logic               advance;
  logic               in_xfer;
  logic               out_room;

  // ---------------- APB configuration ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SCREEN_WIDTH:  prdata = PDATA_W'(screen_width);
      REG_SCREEN_HEIGHT: prdata = PDATA_W'(screen_height);
      default:           prdata = '0;
    endcase
  end

  // ---------------- scaling ----------------
  aprd_axis_scale u_scale_x (
    .axis  (s1_x[AXIS_W-1:0]),
    .size  (screen_width),
    .pixel (scaled_x)
  );

  aprd_axis_scale u_scale_y (
    .axis  (s1_y[AXIS_W-1:0]),
    .size  (screen_height),
    .pixel (scaled_y)
  );

  // ---------------- decode of the staged record ----------------
  always_comb begin
    scaled_ok  = (s1_x <= AXIS_MAX) && (s1_y <= AXIS_MAX);
    is_pointer = (s1_req == REQ_RING) && (s1_type == REC_POINTER) && scaled_ok;
    is_release = (s1_req == REQ_RING) && (s1_type == REC_RELEASE) &&
                 (held_buttons != '0);
    emit       = is_pointer || is_release;

    // a record that emits nothing never waits on the output register
    out_room   = !out_valid || out_ch.ready;
    advance    = s1_valid && (out_room || !emit);
    in_xfer    = in_ch.valid && in_ch.ready;

    held_buttons_next = held_buttons;
    if (s1_req == REQ_REARM) begin
      held_buttons_next = '0;
    end else if (is_pointer) begin
      held_buttons_next = s1_bt;
    end else if (is_release) begin
      held_buttons_next = '0;
    end
  end

  assign in_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req  <= in_ch.req_type;
      s1_type <= in_ch.event_type;
      s1_x    <= in_ch.raw_x;
      s1_y    <= in_ch.raw_y;
      s1_bt   <= in_ch.button_word;
    end
  end

  // state commits when the staged record leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_buttons <= '0;
      last_pixel_x <= '0;
      last_pixel_y <= '0;
    end else if (advance) begin
      held_buttons <= held_buttons_next;
      if (is_pointer) begin
        last_pixel_x <= scaled_x;
        last_pixel_y <= scaled_y;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_room) begin
      out_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_room && advance && emit) begin
      if (is_pointer) begin
        out_x     <= scaled_x;
        out_y     <= scaled_y;
        out_press <= PRESS_W'(s1_bt & BUTTON_MASK);
      end else begin
        out_x     <= last_pixel_x;
        out_y     <= last_pixel_y;
        out_press <= '0;
      end
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.pixel_x = out_x;
  assign out_ch.pixel_y = out_y;
  assign out_ch.pressed = out_press;

endmodule

// ===== hdl/aprd_checker.sv =====
// Checker: port-level assertions for the pointer decoder, bound to the top level.
`timescale 1ns / 1ps
module aprd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [aprd_pkg::PIXEL_W-1:0]  pixel_x,
  input logic [aprd_pkg::PIXEL_W-1:0]  pixel_y,
  input logic [aprd_pkg::PRESS_W-1:0]  pressed
);
  import aprd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("event dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pixel_x) && $stable(pixel_y) && $stable(pressed))
    else $error("event payload changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("event valid right after reset");

  a_event_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("event without a record transfer two cycles earlier");

endmodule

bind abs_pointer_record_decoder_unit aprd_checker u_aprd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pixel_x   (out_ch.pixel_x),
  .pixel_y   (out_ch.pixel_y),
  .pressed   (out_ch.pressed)
);
